// ----- src/pnrd_pkg.sv -----
// Shared types, constants and register codes for the pen report decoder.
// No dependencies; every other file of the block imports this package.
package pnrd_pkg;

    // Longest report that the byte counter handles by default.
    localparam int MAX_REPORT_BYTES_DEF = 21;
    // Shortest report; also the length at and below which the extended
    // fields are not reported.
    localparam int MIN_REPORT_BYTES = 10;

    // Byte positions inside one report.
    localparam int POS_PEN_ID     = 2;
    localparam int POS_STATUS     = 3;
    localparam int POS_X_LO       = 4;
    localparam int POS_X_HI       = 5;
    localparam int POS_Y_LO       = 6;
    localparam int POS_Y_HI       = 7;
    localparam int POS_PRESS_LO   = 8;
    localparam int POS_PRESS_HI   = 9;
    localparam int POS_DISTANCE   = 10;
    localparam int POS_TILT_X_LO  = 11;
    localparam int POS_TILT_X_HI  = 12;
    localparam int POS_TILT_Y_LO  = 13;
    localparam int POS_TILT_Y_HI  = 14;

    // Status byte bits.
    localparam logic [7:0] ST_TIP       = 8'h01;
    localparam logic [7:0] ST_BARREL1   = 8'h02;
    localparam logic [7:0] ST_ERASER    = 8'h04;
    localparam logic [7:0] ST_TOOL_MASK = 8'h0c;
    localparam logic [7:0] ST_BARREL2   = 8'h10;
    localparam logic [7:0] ST_PROX      = 8'h20;

    // Register reset values.
    localparam logic [15:0] X_LIMIT_RST        = 16'hffff;
    localparam logic [15:0] Y_LIMIT_RST        = 16'hffff;
    localparam logic [4:0]  REPORT_LENGTH_RST  = 5'd10;
    localparam logic [15:0] PRESSURE_FLOOR_RST = 16'd110;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_X_LIMIT          = 3'd0,
        REG_Y_LIMIT          = 3'd1,
        REG_REPORT_LENGTH    = 3'd2,
        REG_HEIGHT_SUPPORTED = 3'd3,
        REG_TILT_SUPPORTED   = 3'd4,
        REG_ROTATE_HALF_TURN = 3'd5,
        REG_PRESSURE_FLOOR   = 3'd6
    } reg_idx_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] x_limit;
        logic [15:0] y_limit;
        logic [4:0]  report_length;
        logic        height_supported;
        logic        tilt_supported;
        logic        rotate_half_turn;
        logic [15:0] pressure_floor;
    } cfg_t;

    // Raw fields collected from the report bytes.
    typedef struct packed {
        logic [7:0]  pen_kind;
        logic [7:0]  status_bits;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_pressure;
        logic [7:0]  raw_distance;
        logic [15:0] raw_tilt_x;
        logic [15:0] raw_tilt_y;
    } fields_t;

    // Status from the byte collector to the result stage.
    typedef struct packed {
        logic done;      // a complete report waits in the field registers
        logic extended;  // effective length is above the minimum
    } report_status_t;

endpackage

// ----- src/pen_report_decoder.sv -----
// Top level of the pen report decoder: configuration registers, byte
// collector and result stage. Depends on pnrd_pkg, pnrd_apb, pnrd_capture, pnrd_format.

// The decoder takes one report byte per clock cycle with no gaps needed
// between bytes or between reports. Each byte is written into its field
// register and the byte counter steps in the cycle it is accepted; the
// decoded result is presented from a result register, which loads once the
// done flag is set and it is free. byte_ready drops only while a finished
// report waits and the result register still holds an untaken result, so a
// stalled result side pauses the input one report later. Configuration is
// written through the APB-style port at byte address four times the register
// index and should change only while no report is in flight.
module pen_report_decoder #(
    parameter int MAX_REPORT_BYTES = pnrd_pkg::MAX_REPORT_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  logic [7:0]          report_byte,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [15:0]         x_position,
    output logic [15:0]         y_position,
    output logic [15:0]         pen_pressure,
    output logic                touching,
    output logic                tool_eraser,
    output logic                in_range,
    output logic                side_button_one,
    output logic                side_button_two,
    output logic [7:0]          pen_id,
    output logic [7:0]          hover_distance,
    output logic signed [15:0]  tilt_x_angle,
    output logic signed [15:0]  tilt_y_angle
);
    import pnrd_pkg::*;

    cfg_t           cfg;
    fields_t        fields;
    report_status_t status;
    logic           take;

    // Configuration registers.
    pnrd_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Byte counter and field registers.
    pnrd_capture #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_capture (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .report_byte   (report_byte),
        .report_length (cfg.report_length),
        .take          (take),
        .fields        (fields),
        .status        (status)
    );

    // Result computation and result register.
    pnrd_format u_format (
        .clk             (clk),
        .rst_n           (rst_n),
        .fields          (fields),
        .status          (status),
        .cfg             (cfg),
        .take            (take),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .x_position      (x_position),
        .y_position      (y_position),
        .pen_pressure    (pen_pressure),
        .touching        (touching),
        .tool_eraser     (tool_eraser),
        .in_range        (in_range),
        .side_button_one (side_button_one),
        .side_button_two (side_button_two),
        .pen_id          (pen_id),
        .hover_distance  (hover_distance),
        .tilt_x_angle    (tilt_x_angle),
        .tilt_y_angle    (tilt_y_angle)
    );

endmodule

// ----- src/pnrd_apb.sv -----
// APB-style configuration register file of the pen report decoder.
// Depends on pnrd_pkg for the register codes and the cfg_t type.
module pnrd_apb (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pnrd_pkg::cfg_t      cfg
);
    import pnrd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     write_en;

    assign pready   = 1'b1;
    assign reg_idx  = reg_idx_t'(paddr[4:2]);
    assign write_en = psel & penable & pwrite & pready;
    assign cfg      = cfg_reg;

    // Register write decode; addresses beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_idx)
                REG_X_LIMIT:          cfg_next.x_limit          = pwdata[15:0];
                REG_Y_LIMIT:          cfg_next.y_limit          = pwdata[15:0];
                REG_REPORT_LENGTH:    cfg_next.report_length    = pwdata[4:0];
                REG_HEIGHT_SUPPORTED: cfg_next.height_supported = pwdata[0];
                REG_TILT_SUPPORTED:   cfg_next.tilt_supported   = pwdata[0];
                REG_ROTATE_HALF_TURN: cfg_next.rotate_half_turn = pwdata[0];
                REG_PRESSURE_FLOOR:   cfg_next.pressure_floor   = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_limit          <= X_LIMIT_RST;
            cfg_reg.y_limit          <= Y_LIMIT_RST;
            cfg_reg.report_length    <= REPORT_LENGTH_RST;
            cfg_reg.height_supported <= 1'b0;
            cfg_reg.tilt_supported   <= 1'b0;
            cfg_reg.rotate_half_turn <= 1'b0;
            cfg_reg.pressure_floor   <= PRESSURE_FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_X_LIMIT:          prdata = {16'd0, cfg_reg.x_limit};
            REG_Y_LIMIT:          prdata = {16'd0, cfg_reg.y_limit};
            REG_REPORT_LENGTH:    prdata = {27'd0, cfg_reg.report_length};
            REG_HEIGHT_SUPPORTED: prdata = {31'd0, cfg_reg.height_supported};
            REG_TILT_SUPPORTED:   prdata = {31'd0, cfg_reg.tilt_supported};
            REG_ROTATE_HALF_TURN: prdata = {31'd0, cfg_reg.rotate_half_turn};
            REG_PRESSURE_FLOOR:   prdata = {16'd0, cfg_reg.pressure_floor};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/pnrd_capture.sv -----
// Byte counter and field registers of the pen report decoder.
// Depends on pnrd_pkg for byte positions and the fields_t type.
module pnrd_capture #(
    parameter int MAX_REPORT_BYTES = pnrd_pkg::MAX_REPORT_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [7:0]                  report_byte,
    input  logic [4:0]                  report_length,
    input  logic                        take,
    output pnrd_pkg::fields_t           fields,
    output pnrd_pkg::report_status_t    status
);
    import pnrd_pkg::*;

    localparam int POS_W  = $clog2(MAX_REPORT_BYTES);
    localparam int LEN_LW = $clog2(MAX_REPORT_BYTES + 1);
    localparam int LEN_W  = (LEN_LW > 5) ? LEN_LW : 5;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    fields_t          fields_reg;
    fields_t          fields_next;
    logic             done_reg;
    logic             done_next;
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos_plus;
    logic             last_byte;
    logic             accept;

    // Effective length, saturated to the supported range.
    always_comb
    begin
        len_raw = LEN_W'(report_length);
        priority if (len_raw > LEN_W'(MAX_REPORT_BYTES))
            eff_len = LEN_W'(MAX_REPORT_BYTES);
        else if (len_raw < LEN_W'(MIN_REPORT_BYTES))
            eff_len = LEN_W'(MIN_REPORT_BYTES);
        else
            eff_len = len_raw;
    end

    // A request is held off only while a finished report cannot move on.
    assign byte_ready = !done_reg || take;
    assign accept     = byte_valid && byte_ready;
    assign pos_plus   = LEN_W'(pos_reg) + LEN_W'(1);
    assign last_byte  = (pos_plus >= eff_len);

    // Field capture at fixed byte positions.
    always_comb
    begin
        fields_next = fields_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            unique case (pos_reg)
                POS_W'(POS_PEN_ID):    fields_next.pen_kind           = report_byte;
                POS_W'(POS_STATUS):    fields_next.status_bits        = report_byte;
                POS_W'(POS_X_LO):      fields_next.raw_x[7:0]         = report_byte;
                POS_W'(POS_X_HI):      fields_next.raw_x[15:8]        = report_byte;
                POS_W'(POS_Y_LO):      fields_next.raw_y[7:0]         = report_byte;
                POS_W'(POS_Y_HI):      fields_next.raw_y[15:8]        = report_byte;
                POS_W'(POS_PRESS_LO):  fields_next.raw_pressure[7:0]  = report_byte;
                POS_W'(POS_PRESS_HI):  fields_next.raw_pressure[15:8] = report_byte;
                POS_W'(POS_DISTANCE):  fields_next.raw_distance       = report_byte;
                POS_W'(POS_TILT_X_LO): fields_next.raw_tilt_x[7:0]    = report_byte;
                POS_W'(POS_TILT_X_HI): fields_next.raw_tilt_x[15:8]   = report_byte;
                POS_W'(POS_TILT_Y_LO): fields_next.raw_tilt_y[7:0]    = report_byte;
                POS_W'(POS_TILT_Y_HI): fields_next.raw_tilt_y[15:8]   = report_byte;
                default:               fields_next = fields_reg;
            endcase
            pos_next = last_byte ? '0 : pos_reg + POS_W'(1);
        end
    end

    // The done flag marks a complete report until the result stage takes it.
    always_comb
    begin
        priority if (accept && last_byte)
            done_next = 1'b1;
        else if (take)
            done_next = 1'b0;
        else
            done_next = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fields_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            fields_reg <= fields_next;
            done_reg   <= done_next;
        end
    end

    assign fields          = fields_reg;
    assign status.done     = done_reg;
    assign status.extended = (eff_len > LEN_W'(MIN_REPORT_BYTES));

`ifndef SYNTHESIS
    // The byte counter stays inside the longest report.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(pos_reg) < LEN_W'(MAX_REPORT_BYTES))
        else $error("byte counter beyond the longest report");

    // The last byte of a report always raises the done flag.
    a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> done_reg)
        else $error("finished report not flagged");

    // A finished report is not dropped before the result stage takes it.
    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !take) |=> done_reg)
        else $error("finished report lost");
`endif

endmodule

// ----- src/pnrd_format.sv -----
// Result stage of the pen report decoder: mirroring, clamping, pressure
// floor, tool latch and the result register. Depends on pnrd_pkg.
module pnrd_format (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pnrd_pkg::fields_t           fields,
    input  pnrd_pkg::report_status_t    status,
    input  pnrd_pkg::cfg_t              cfg,
    output logic                        take,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [15:0]                 x_position,
    output logic [15:0]                 y_position,
    output logic [15:0]                 pen_pressure,
    output logic                        touching,
    output logic                        tool_eraser,
    output logic                        in_range,
    output logic                        side_button_one,
    output logic                        side_button_two,
    output logic [7:0]                  pen_id,
    output logic [7:0]                  hover_distance,
    output logic signed [15:0]          tilt_x_angle,
    output logic signed [15:0]          tilt_y_angle
);
    import pnrd_pkg::*;

    typedef struct packed {
        logic [15:0] x_position;
        logic [15:0] y_position;
        logic [15:0] pen_pressure;
        logic        touching;
        logic        tool_eraser;
        logic        in_range;
        logic        side_button_one;
        logic        side_button_two;
        logic [7:0]  pen_id;
        logic [7:0]  hover_distance;
        logic [15:0] tilt_x_angle;
        logic [15:0] tilt_y_angle;
    } result_t;

    result_t result_reg;
    result_t result_next;
    logic    valid_reg;
    logic    valid_next;
    logic    prox_reg;
    logic    prox_next;
    logic    eraser_reg;
    logic    eraser_next;
    logic    ext_height;
    logic    ext_tilt;

    // Optional mirror about the limit, then clamp to the limit.
    function automatic logic [15:0] place(input logic [15:0] raw,
                                          input logic [15:0] limit,
                                          input logic        rotate);
        logic [15:0] v;
        if (rotate)
            v = (raw > limit) ? 16'd0 : limit - raw;
        else
            v = (raw > limit) ? limit : raw;
        return v;
    endfunction

    // A finished report loads the result register when it is empty or being emptied.
    assign take = status.done && (!valid_reg || result_ready);

    // Tool latch: the tool type follows the status only while out of range.
    always_comb
    begin
        eraser_next = eraser_reg;
        prox_next   = prox_reg;
        if (take)
        begin
            if (!prox_reg)
                eraser_next = |(fields.status_bits & ST_TOOL_MASK);
            prox_next = |(fields.status_bits & ST_PROX);
        end
    end

    assign ext_height = status.extended && cfg.height_supported;
    assign ext_tilt   = status.extended && cfg.tilt_supported;

    // Decoded result.
    always_comb
    begin
        result_next = result_reg;
        if (take)
        begin
            result_next.x_position      = place(fields.raw_x, cfg.x_limit,
                                                cfg.rotate_half_turn);
            result_next.y_position      = place(fields.raw_y, cfg.y_limit,
                                                cfg.rotate_half_turn);
            result_next.pen_pressure    = (fields.raw_pressure < cfg.pressure_floor)
                                          ? 16'd0 : fields.raw_pressure;
            result_next.touching        = |(fields.status_bits & (ST_TIP | ST_ERASER));
            result_next.tool_eraser     = eraser_next;
            result_next.in_range        = prox_next;
            result_next.side_button_one = |(fields.status_bits & ST_BARREL1);
            result_next.side_button_two = |(fields.status_bits & ST_BARREL2);
            result_next.pen_id          = fields.pen_kind;
            result_next.hover_distance  = ext_height ? fields.raw_distance : 8'd0;
            result_next.tilt_x_angle    = ext_tilt ? fields.raw_tilt_x : 16'd0;
            result_next.tilt_y_angle    = ext_tilt ? fields.raw_tilt_y : 16'd0;
        end
    end

    // Result valid flag.
    always_comb
    begin
        priority if (take)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            prox_reg   <= 1'b0;
            eraser_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            prox_reg   <= prox_next;
            eraser_reg <= eraser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid    = valid_reg;
    assign x_position      = result_reg.x_position;
    assign y_position      = result_reg.y_position;
    assign pen_pressure    = result_reg.pen_pressure;
    assign touching        = result_reg.touching;
    assign tool_eraser     = result_reg.tool_eraser;
    assign in_range        = result_reg.in_range;
    assign side_button_one = result_reg.side_button_one;
    assign side_button_two = result_reg.side_button_two;
    assign pen_id          = result_reg.pen_id;
    assign hover_distance  = result_reg.hover_distance;
    assign tilt_x_angle    = signed'(result_reg.tilt_x_angle);
    assign tilt_y_angle    = signed'(result_reg.tilt_y_angle);

`ifndef SYNTHESIS
    // Taking a finished report always presents a result next cycle.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("taken report not presented");

    // The tool type only changes when the pen was out of range.
    a_tool_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (eraser_reg != $past(eraser_reg)) |-> !$past(prox_reg))
        else $error("tool type changed while in range");

    // A presented result shows the latched proximity state.
    a_prox_match: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result_reg.in_range == prox_reg))
        else $error("in_range differs from the proximity latch");
`endif

endmodule

// ----- sim/pen_report_decoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench for pen_report_decoder: streams report bytes with random gaps and
// stalls, predicts every decoded report and checks each result field by field.
// Depends on pnrd_pkg and the pen_report_decoder RTL.
module pen_report_decoder_tb;
    import pnrd_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TOTAL_BYTES      = 1020;
    localparam int MAX_SHOWN        = 10;
    localparam longint TIMEOUT_NS   = 4000000;

    // One decoded report as it leaves the block.
    typedef struct packed {
        logic [15:0]        x_position;
        logic [15:0]        y_position;
        logic [15:0]        pen_pressure;
        logic               touching;
        logic               tool_eraser;
        logic               in_range;
        logic               side_button_one;
        logic               side_button_two;
        logic [7:0]         pen_id;
        logic [7:0]         hover_distance;
        logic signed [15:0] tilt_x_angle;
        logic signed [15:0] tilt_y_angle;
    } pen_sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    logic [7:0]         report_byte = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [15:0]        x_position;
    logic [15:0]        y_position;
    logic [15:0]        pen_pressure;
    logic               touching;
    logic               tool_eraser;
    logic               in_range;
    logic               side_button_one;
    logic               side_button_two;
    logic [7:0]         pen_id;
    logic [7:0]         hover_distance;
    logic signed [15:0] tilt_x_angle;
    logic signed [15:0] tilt_y_angle;

    // Decoder state mirrored by the testbench.
    cfg_t        model_cfg;
    fields_t     model_raw;
    int unsigned model_pos;
    logic        model_prox;
    logic        model_eraser;
    pen_sample_t pending_reports[$];

    int error_count = 0;
    int bytes_sent = 0;
    int sink_hold_request = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;

    pen_report_decoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .report_byte     (report_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .x_position      (x_position),
        .y_position      (y_position),
        .pen_pressure    (pen_pressure),
        .touching        (touching),
        .tool_eraser     (tool_eraser),
        .in_range        (in_range),
        .side_button_one (side_button_one),
        .side_button_two (side_button_two),
        .pen_id          (pen_id),
        .hover_distance  (hover_distance),
        .tilt_x_angle    (tilt_x_angle),
        .tilt_y_angle    (tilt_y_angle)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Lengths outside the supported range saturate at either end.
    function automatic int unsigned effective_length();
        int unsigned n;
        n = 32'(model_cfg.report_length);
        if (n > MAX_REPORT_BYTES_DEF) n = MAX_REPORT_BYTES_DEF;
        if (n < MIN_REPORT_BYTES) n = MIN_REPORT_BYTES;
        return n;
    endfunction

    // Optional half-turn mirror, clamped at zero, then clamped to the limit.
    function automatic logic [15:0] place_coord(input logic [15:0] raw,
                                                input logic [15:0] limit);
        logic [15:0] v;
        v = raw;
        if (model_cfg.rotate_half_turn) v = (raw > limit) ? 16'h0000 : limit - raw;
        if (v > limit) v = limit;
        return v;
    endfunction

    // Absorbs one accepted byte; on the last byte of a report it queues the
    // decoded result.
    function automatic void decode_byte(input logic [7:0] b);
        int unsigned span;
        logic        ext;
        pen_sample_t s;
        span = effective_length();
        case (model_pos)
            POS_PEN_ID:    model_raw.pen_kind = b;
            POS_STATUS:    model_raw.status_bits = b;
            POS_X_LO:      model_raw.raw_x[7:0] = b;
            POS_X_HI:      model_raw.raw_x[15:8] = b;
            POS_Y_LO:      model_raw.raw_y[7:0] = b;
            POS_Y_HI:      model_raw.raw_y[15:8] = b;
            POS_PRESS_LO:  model_raw.raw_pressure[7:0] = b;
            POS_PRESS_HI:  model_raw.raw_pressure[15:8] = b;
            POS_DISTANCE:  model_raw.raw_distance = b;
            POS_TILT_X_LO: model_raw.raw_tilt_x[7:0] = b;
            POS_TILT_X_HI: model_raw.raw_tilt_x[15:8] = b;
            POS_TILT_Y_LO: model_raw.raw_tilt_y[7:0] = b;
            POS_TILT_Y_HI: model_raw.raw_tilt_y[15:8] = b;
            default: ;
        endcase
        if (model_pos + 1 < span) begin
            model_pos++;
            return;
        end
        model_pos = 0;

        // The tool type only follows the status while the pen was out of range.
        if (!model_prox) model_eraser = |(model_raw.status_bits & ST_TOOL_MASK);
        model_prox = |(model_raw.status_bits & ST_PROX);

        ext = span > MIN_REPORT_BYTES;
        s.x_position      = place_coord(model_raw.raw_x, model_cfg.x_limit);
        s.y_position      = place_coord(model_raw.raw_y, model_cfg.y_limit);
        s.pen_pressure    = (model_raw.raw_pressure < model_cfg.pressure_floor) ?
                            16'h0000 : model_raw.raw_pressure;
        s.touching        = |(model_raw.status_bits & (ST_TIP | ST_ERASER));
        s.tool_eraser     = model_eraser;
        s.in_range        = model_prox;
        s.side_button_one = |(model_raw.status_bits & ST_BARREL1);
        s.side_button_two = |(model_raw.status_bits & ST_BARREL2);
        s.pen_id          = model_raw.pen_kind;
        s.hover_distance  = (ext && model_cfg.height_supported) ?
                            model_raw.raw_distance : 8'h00;
        s.tilt_x_angle    = (ext && model_cfg.tilt_supported) ?
                            model_raw.raw_tilt_x : 16'h0000;
        s.tilt_y_angle    = (ext && model_cfg.tilt_supported) ?
                            model_raw.raw_tilt_y : 16'h0000;
        pending_reports.push_back(s);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report_error($sformatf("%s: expected %h, got %h", name, want, got));
    endtask

    // Every accepted result is compared with the oldest decoded report.
    always @(posedge clk) begin : report_check
        pen_sample_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_reports.size() == 0) begin
                report_error("result arrived with no report pending");
            end
            else begin
                want = pending_reports.pop_front();
                check_field("x_position", want.x_position, x_position);
                check_field("y_position", want.y_position, y_position);
                check_field("pen_pressure", want.pen_pressure, pen_pressure);
                check_field("touching", 16'(want.touching), 16'(touching));
                check_field("tool_eraser", 16'(want.tool_eraser), 16'(tool_eraser));
                check_field("in_range", 16'(want.in_range), 16'(in_range));
                check_field("side_button_one", 16'(want.side_button_one),
                            16'(side_button_one));
                check_field("side_button_two", 16'(want.side_button_two),
                            16'(side_button_two));
                check_field("pen_id", 16'(want.pen_id), 16'(pen_id));
                check_field("hover_distance", 16'(want.hover_distance),
                            16'(hover_distance));
                check_field("tilt_x_angle", want.tilt_x_angle, tilt_x_angle);
                check_field("tilt_y_angle", want.tilt_y_angle, tilt_y_angle);
            end
        end
    end

    // Result side: a random wait after each taken result, steady stretches,
    // and a long hold-off on request, all counted here in cycles.
    initial begin : result_sink
        int hold;
        hold = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (sink_hold_request > 0) begin
                hold = sink_hold_request;
                sink_hold_request = 0;
            end
            else if (result_valid && result_ready) begin
                hold = sink_steady ? 0 : $urandom_range(0, 3);
            end
            else if (hold > 0) begin
                hold--;
            end
            result_ready <= (hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one byte request after a random gap; valid stays high afterwards
    // so that the next byte can follow without a bubble.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid  <= 1'b1;
        report_byte <= b;
        do @(posedge clk); while (!byte_ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Stops sending and waits until every queued report has come out or the drain limit is reached.
    task automatic drain_results();
        int waited;
        byte_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then an idle cycle on the bus.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_X_LIMIT:          model_cfg.x_limit = value[15:0];
            REG_Y_LIMIT:          model_cfg.y_limit = value[15:0];
            REG_REPORT_LENGTH:    model_cfg.report_length = value[4:0];
            REG_HEIGHT_SUPPORTED: model_cfg.height_supported = value[0];
            REG_TILT_SUPPORTED:   model_cfg.tilt_supported = value[0];
            REG_ROTATE_HALF_TURN: model_cfg.rotate_half_turn = value[0];
            REG_PRESSURE_FLOOR:   model_cfg.pressure_floor = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [15:0] x_lim, input logic [15:0] y_lim,
                                input logic [4:0] len, input logic height,
                                input logic tilt, input logic rotate,
                                input logic [15:0] floor_value);
        drain_results();
        write_reg(REG_X_LIMIT, {16'h0000, x_lim});
        write_reg(REG_Y_LIMIT, {16'h0000, y_lim});
        write_reg(REG_REPORT_LENGTH, {27'h0, len});
        write_reg(REG_HEIGHT_SUPPORTED, {31'h0, height});
        write_reg(REG_TILT_SUPPORTED, {31'h0, tilt});
        write_reg(REG_ROTATE_HALF_TURN, {31'h0, rotate});
        write_reg(REG_PRESSURE_FLOOR, {16'h0000, floor_value});
    endtask

    // A value at, or just around, a reference point, at an extreme, or random.
    function automatic logic [15:0] pick_word(input logic [15:0] ref_value);
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return ref_value;
            3:       return ref_value - 16'd1;
            4:       return ref_value + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // One report of the current length with the given status byte.
    task automatic send_random_report(input logic [7:0] status);
        logic [7:0]  frame [MAX_REPORT_BYTES_DEF];
        logic [15:0] xv, yv, pv, txv, tyv;
        int unsigned span;
        span = effective_length();
        foreach (frame[i]) frame[i] = 8'($urandom);
        xv  = pick_word(model_cfg.x_limit);
        yv  = pick_word(model_cfg.y_limit);
        pv  = pick_word(model_cfg.pressure_floor);
        txv = pick_word(16'h8000);
        tyv = pick_word(16'h8000);
        frame[POS_STATUS]    = status;
        frame[POS_X_LO]      = xv[7:0];
        frame[POS_X_HI]      = xv[15:8];
        frame[POS_Y_LO]      = yv[7:0];
        frame[POS_Y_HI]      = yv[15:8];
        frame[POS_PRESS_LO]  = pv[7:0];
        frame[POS_PRESS_HI]  = pv[15:8];
        frame[POS_TILT_X_LO] = txv[7:0];
        frame[POS_TILT_X_HI] = txv[15:8];
        frame[POS_TILT_Y_LO] = tyv[7:0];
        frame[POS_TILT_Y_HI] = tyv[15:8];
        for (int i = 0; i < span; i++) send_byte(frame[i]);
    endtask

    // Fills out a report left open by an earlier phase.
    task automatic finish_report();
        while (model_pos != 0) send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the registers with all-ones, all-zeros and a report
    // whose pressure sits exactly on the floor.
    task automatic test_field_extremes();
        logic [7:0] frame [MIN_REPORT_BYTES];
        repeat (MIN_REPORT_BYTES) send_byte(8'hff);
        repeat (MIN_REPORT_BYTES) send_byte(8'h00);
        foreach (frame[i]) frame[i] = 8'h00;
        frame[POS_PEN_ID]   = 8'h5a;
        frame[POS_STATUS]   = ST_TIP | ST_PROX;
        frame[POS_X_LO]     = 8'h34;
        frame[POS_X_HI]     = 8'h12;
        frame[POS_Y_LO]     = 8'h78;
        frame[POS_Y_HI]     = 8'h56;
        frame[POS_PRESS_LO] = PRESSURE_FLOOR_RST[7:0];
        frame[POS_PRESS_HI] = PRESSURE_FLOOR_RST[15:8];
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // Coordinate limits at both extremes and at random, with and without
    // the half-turn mirror, and the pressure floor at its extremes and at random.
    task automatic test_coordinate_limits();
        logic [15:0] lim, flr;
        for (int i = 0; i < 6; i++) begin
            case (i / 2)
                0:       lim = 16'h0000;
                1:       lim = 16'hffff;
                default: lim = 16'($urandom);
            endcase
            case (i % 3)
                0:       flr = 16'h0000;
                1:       flr = 16'hffff;
                default: flr = 16'($urandom);
            endcase
            apply_config(lim, (i / 2 == 2) ? 16'($urandom) : lim, REPORT_LENGTH_RST,
                         1'b0, 1'b0, i[0], flr);
            repeat (3) send_random_report(8'($urandom));
        end
    endtask

    // Distance and tilt across report lengths, including lengths below the
    // minimum and above the maximum, with the support bits in several mixes.
    task automatic test_extended_fields();
        logic [4:0] lengths [8];
        lengths = '{5'd10, 5'd11, 5'd15, 5'd21, 5'd0, 5'd9, 5'd22, 5'd31};
        foreach (lengths[i]) begin
            apply_config(16'hffff, 16'hffff, lengths[i], 1'b1, 1'b1, 1'b0,
                         PRESSURE_FLOOR_RST);
            send_random_report(8'($urandom));
            apply_config(16'hffff, 16'hffff, lengths[i], i[0], !i[0], 1'b0,
                         PRESSURE_FLOOR_RST);
            send_random_report(8'($urandom));
        end
    endtask

    // Length written while a report is half collected.
    task automatic test_length_change_mid_report();
        apply_config(16'hffff, 16'hffff, 5'd21, 1'b1, 1'b1, 1'b0, PRESSURE_FLOOR_RST);
        // Shortened below the current count: the next byte closes the report.
        repeat (12) send_byte(8'($urandom));
        drain_results();
        write_reg(REG_REPORT_LENGTH, 32'd11);
        send_byte(8'($urandom));
        send_random_report(8'($urandom));
        // Lengthened part way through.
        repeat (5) send_byte(8'($urandom));
        drain_results();
        write_reg(REG_REPORT_LENGTH, 32'd21);
        finish_report();
        // Written below the minimum once the count is already past it.
        repeat (15) send_byte(8'($urandom));
        drain_results();
        write_reg(REG_REPORT_LENGTH, 32'd4);
        send_byte(8'($urandom));
        send_random_report(8'($urandom));
    endtask

    // Proximity walks in and out of range so the tool latch both follows
    // and holds.
    task automatic test_tool_latch();
        logic       prox;
        logic [7:0] st;
        apply_config(16'hffff, 16'hffff, REPORT_LENGTH_RST, 1'b0, 1'b0, 1'b0,
                     PRESSURE_FLOOR_RST);
        prox = 1'b0;
        repeat (12) begin
            st = 8'($urandom);
            st = prox ? (st | ST_PROX) : (st & ~ST_PROX);
            if ($urandom_range(0, 2) == 0) prox = !prox;
            send_random_report(st);
        end
    endtask

    // The result side holds off while bytes keep coming so the input stalls;
    // later the sender pauses mid-report until every result is out.
    task automatic test_backpressure();
        sink_hold_request = LONG_HOLD_CYCLES;
        src_steady = 1'b1;
        repeat (6) send_random_report(8'($urandom));
        src_steady = 1'b0;
        repeat (4) send_byte(8'($urandom));
        drain_results();
        finish_report();
        sink_steady = 1'b1;
        src_steady = 1'b1;
        repeat (4) send_random_report(8'($urandom));
        sink_steady = 1'b0;
        src_steady = 1'b0;
    endtask

    // Random settings, runs of whole reports and occasional stray tails.
    task automatic test_random_mix();
        logic [4:0] len;
        while (bytes_sent < TOTAL_BYTES) begin
            len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                                5'($urandom_range(10, 21));
            apply_config(pick_word(16'($urandom)), pick_word(16'($urandom)), len,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), pick_word(PRESSURE_FLOOR_RST));
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            finish_report();
            repeat ($urandom_range(1, 6)) send_random_report(8'($urandom));
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        model_cfg = '{x_limit: X_LIMIT_RST, y_limit: Y_LIMIT_RST,
                      report_length: REPORT_LENGTH_RST, height_supported: 1'b0,
                      tilt_supported: 1'b0, rotate_half_turn: 1'b0,
                      pressure_floor: PRESSURE_FLOOR_RST};
        model_raw    = '0;
        model_pos    = 0;
        model_prox   = 1'b0;
        model_eraser = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_coordinate_limits();
        test_extended_fields();
        test_length_change_mid_report();
        test_tool_latch();
        test_backpressure();
        test_random_mix();

        drain_results();
        if (pending_reports.size() != 0)
            report_error($sformatf("%0d reports never came out", pending_reports.size()));
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- pen_report_decoder.f -----
src/pnrd_pkg.sv
src/pnrd_apb.sv
src/pnrd_capture.sv
src/pnrd_format.sv
src/pen_report_decoder.sv
sim/pen_report_decoder_tb.sv
